>>> hw/rtl/dmc_pkg.sv
// Shared types and constants for the delta-modulation channel.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dmc_pkg;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_ENABLE  = 2'd1,
      OP_RESTART = 2'd2,
      OP_DIRECT  = 2'd3
   } op_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_COUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_EN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IRQ_EN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PER   = 3'd4;

   localparam logic [15:0] RST_START_ADDR = 16'hC000;
   localparam logic [11:0] RST_BYTE_COUNT = 12'd1;
   localparam logic [7:0]  RST_HALF_PER   = 8'd214;

   localparam logic [15:0] ADDR_LAST    = 16'hFFFF;
   localparam logic [15:0] ADDR_WRAP    = 16'h8000;
   localparam logic [6:0]  LEVEL_TOP    = 7'd125;  // highest level that can still go up by 2
   localparam logic [6:0]  LEVEL_SILENT = 7'd64;
   localparam logic [3:0]  BITS_FULL    = 4'd8;

   typedef struct packed {
      logic [15:0] start_addr;
      logic [11:0] byte_count;
      logic        loop_en;
      logic        irq_en;
      logic [7:0]  half_period;
   } cfg_type;

   typedef struct packed {
      logic [6:0]  level;
      logic [15:0] fetch_address;
      logic        byte_taken;
      logic        irq_raised;
   } result_type;

   // Corrected timer wrap value after a half-period change.
   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } tmr_fix_type;

endpackage

>>> hw/rtl/dmc_csr_regs.sv
// Configuration registers of the delta-modulation channel.
// Depends on dmc_pkg.
`timescale 1ns / 1ps

module dmc_csr_regs
   import dmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_ADDR: cfg_in.start_addr  = csr_wdata;
            CSR_BYTE_COUNT: cfg_in.byte_count  = csr_wdata[11:0];
            CSR_LOOP_EN:    cfg_in.loop_en     = csr_wdata[0];
            CSR_IRQ_EN:     cfg_in.irq_en      = csr_wdata[0];
            CSR_HALF_PER:   cfg_in.half_period = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_addr  <= RST_START_ADDR;
         cfg_ff.byte_count  <= RST_BYTE_COUNT;
         cfg_ff.loop_en     <= 1'b0;
         cfg_ff.irq_en      <= 1'b0;
         cfg_ff.half_period <= RST_HALF_PER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/dmc_timer_mod.sv
// Bit-serial remainder unit: after a half-period write it works out
// (timer + 1) mod period, one quotient bit per cycle. Depends on dmc_pkg.
`timescale 1ns / 1ps

module dmc_timer_mod
   import dmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,        // half-period register written
   input  logic [7:0]  new_period,
   input  logic [7:0]  tick_timer,
   input  logic        tick_accept,  // fix is used up by the next tick
   output logic        busy,
   output tmr_fix_type fix
);

   logic        busy_ff, busy_in;
   logic [3:0]  count_ff, count_in;
   logic [8:0]  dividend_ff, dividend_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  divisor_ff, divisor_in;
   logic        fix_valid_ff, fix_valid_in;

   logic [8:0]  trial;

   always_comb begin
      busy_in      = busy_ff;
      count_in     = count_ff;
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      fix_valid_in = fix_valid_ff;
      trial        = {rem_ff, dividend_ff[8]};

      if (start) begin
         busy_in      = 1'b1;
         count_in     = 4'd9;
         dividend_in  = {1'b0, tick_timer} + 9'd1;
         rem_in       = '0;
         // a zero period behaves as one
         divisor_in   = (new_period == 8'd0) ? 8'd1 : new_period;
         fix_valid_in = 1'b0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits in 8 bits
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = 8'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[7:0];
         end
         dividend_in = {dividend_ff[7:0], 1'b0};
         count_in    = count_ff - 4'd1;
         if (count_ff == 4'd1) begin
            busy_in      = 1'b0;
            fix_valid_in = 1'b1;
         end
      end else if (tick_accept) begin
         fix_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         fix_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         fix_valid_ff <= fix_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
   end

   assign busy      = busy_ff;
   assign fix.valid = fix_valid_ff;
   assign fix.value = rem_ff;

endmodule

>>> hw/rtl/dmc_core.sv
// Channel state and its single-pass update for one item: memory reader,
// output unit and tick timer. Depends on dmc_pkg.
`timescale 1ns / 1ps

module dmc_core
   import dmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        accept,
   input  op_type      op,
   input  logic        enable_bit,
   input  logic [6:0]  direct_level,
   input  logic [7:0]  mem_byte,
   input  tmr_fix_type fix,
   output logic [7:0]  tick_timer,
   output result_type  result
);

   logic [15:0] addr_ff, addr_in;
   logic [11:0] bytes_ff, bytes_in;
   logic [7:0]  shift_ff, shift_in;
   logic [3:0]  bits_ff, bits_in;
   logic [6:0]  level_ff, level_in;
   logic        empty_ff, empty_in;
   logic        silent_ff, silent_in;
   logic [7:0]  timer_ff, timer_in;
   logic [6:0]  pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;
   logic        on_ff, on_in;
   logic        taken;
   logic        irq;

   always_comb begin
      logic [7:0] half;
      logic [7:0] timer_inc;
      half      = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
      timer_inc = timer_ff + 8'd1;

      addr_in       = addr_ff;
      bytes_in      = bytes_ff;
      shift_in      = shift_ff;
      bits_in       = bits_ff;
      level_in      = level_ff;
      empty_in      = empty_ff;
      silent_in     = silent_ff;
      timer_in      = timer_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      on_in         = on_ff;
      taken         = 1'b0;
      irq           = 1'b0;

      case (op)
         OP_ENABLE: on_in = enable_bit;
         OP_RESTART: begin
            addr_in  = cfg.start_addr;
            bytes_in = cfg.byte_count;
         end
         OP_DIRECT: begin
            pend_in       = direct_level;
            pend_valid_in = 1'b1;
         end
         OP_TICK: begin
            // memory reader
            if (on_ff && empty_ff && (bytes_ff != 12'd0)) begin
               taken    = 1'b1;
               addr_in  = (addr_ff == ADDR_LAST) ? ADDR_WRAP : addr_ff + 16'd1;
               bytes_in = bytes_ff - 12'd1;
               if ((bytes_in == 12'd0) && cfg.loop_en) begin
                  addr_in  = cfg.start_addr;
                  bytes_in = cfg.byte_count;
               end
               irq       = (bytes_in == 12'd0) && cfg.irq_en;
               shift_in  = mem_byte;
               bits_in   = BITS_FULL;
               silent_in = 1'b0;
               empty_in  = 1'b0;
            end
            // output unit, sees the reader's update
            if (timer_ff == 8'd0) begin
               if (pend_valid_ff) begin
                  level_in      = pend_ff;
                  pend_valid_in = 1'b0;
               end else if (!silent_in) begin
                  if (shift_in[0]) begin
                     if (level_ff <= LEVEL_TOP) level_in = level_ff + 7'd2;
                  end else begin
                     if (level_ff >= 7'd2) level_in = level_ff - 7'd2;
                  end
                  shift_in = {1'b0, shift_in[7:1]};
                  if (bits_in != 4'd0) bits_in = bits_in - 4'd1;
                  if (bits_in == 4'd0) begin
                     bits_in = BITS_FULL;
                     if (empty_in) begin
                        silent_in = 1'b1;
                        level_in  = LEVEL_SILENT;
                     end else begin
                        empty_in = 1'b1;
                     end
                  end
               end
            end
            // tick timer; after a period change the wrap comes from the remainder unit
            if (fix.valid) timer_in = fix.value;
            else if (timer_inc == half) timer_in = 8'd0;
            else timer_in = timer_inc;
         end
         default: on_in = on_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         bytes_ff      <= '0;
         shift_ff      <= '0;
         bits_ff       <= BITS_FULL;
         level_ff      <= '0;
         empty_ff      <= 1'b1;
         silent_ff     <= 1'b1;
         timer_ff      <= '0;
         pend_ff       <= '0;
         pend_valid_ff <= 1'b0;
         on_ff         <= 1'b0;
      end else if (accept) begin
         addr_ff       <= addr_in;
         bytes_ff      <= bytes_in;
         shift_ff      <= shift_in;
         bits_ff       <= bits_in;
         level_ff      <= level_in;
         empty_ff      <= empty_in;
         silent_ff     <= silent_in;
         timer_ff      <= timer_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
         on_ff         <= on_in;
      end
   end

   assign tick_timer           = timer_ff;
   assign result.level         = level_in;
   assign result.fetch_address = addr_in;
   assign result.byte_taken    = taken;
   assign result.irq_raised    = irq;

endmodule

>>> hw/rtl/dmc_rsp_buffer.sv
// Result register with a skid entry, so an item is taken while a result waits.
// Depends on dmc_pkg.
`timescale 1ns / 1ps

module dmc_rsp_buffer
   import dmc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_load,
   input  result_type in_data,
   output logic       skid_full,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       out_free;

   always_comb begin
      out_free      = !main_valid_ff || !out_stall;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (in_load) begin
         if (out_free) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_free) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign skid_full = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

>>> hw/rtl/delta_modulation_channel_unit.sv
// Top level of the delta-modulation sound channel.
// Depends on dmc_pkg, dmc_csr_regs, dmc_timer_mod, dmc_core, dmc_rsp_buffer.
//
// Usage:
//   req_* carries one item per audio clock: op selects tick, set enable,
//   restart sample or queue a direct level. req_mem_byte must hold the byte
//   at the address reported by the previous result (rsp_fetch_address).
//   rsp_* returns one result per item: level, next fetch address, and
//   byte_taken / irq_raised pulses for ticks.
//   csr_* writes the five configuration registers while the channel is idle.
// Each result is registered (output register, or skid entry under stall).
// Throughput: one item per cycle while req_stall is low; the channel state
// updates in a single pass. A write to the timer half-period register starts
// a bit-serial remainder unit that fixes up the timer wrap; req_stall is high
// meanwhile. Reset (synchronous) loads the register defaults, silences the
// channel and empties the result buffer. When the receiver stalls, one more
// item is taken into a skid entry; req_stall then rises until it drains.
`timescale 1ns / 1ps

module delta_modulation_channel_unit
   import dmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic                   req_enable_bit,
   input  logic [6:0]             req_direct_level,
   input  logic [7:0]             req_mem_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [6:0]             rsp_level,
   output logic [15:0]            rsp_fetch_address,
   output logic                   rsp_byte_taken,
   output logic                   rsp_irq_raised,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type     cfg;
   tmr_fix_type fix;
   result_type  core_result;
   result_type  rsp_data;
   op_type      op;
   logic        accept;
   logic        mod_busy;
   logic        skid_full;
   logic [7:0]  tick_timer;

   assign op        = op_type'(req_op);
   assign req_stall = skid_full || mod_busy;
   assign accept    = req_valid && !req_stall;

   dmc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dmc_timer_mod u_tmr (
      .clock       (clock),
      .reset       (reset),
      .start       (csr_wr_en && (csr_index == CSR_HALF_PER)),
      .new_period  (csr_wdata[7:0]),
      .tick_timer  (tick_timer),
      .tick_accept (accept && (op == OP_TICK)),
      .busy        (mod_busy),
      .fix         (fix)
   );

   dmc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .accept       (accept),
      .op           (op),
      .enable_bit   (req_enable_bit),
      .direct_level (req_direct_level),
      .mem_byte     (req_mem_byte),
      .fix          (fix),
      .tick_timer   (tick_timer),
      .result       (core_result)
   );

   dmc_rsp_buffer u_buf (
      .clock     (clock),
      .reset     (reset),
      .in_load   (accept),
      .in_data   (core_result),
      .skid_full (skid_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_level         = rsp_data.level;
   assign rsp_fetch_address = rsp_data.fetch_address;
   assign rsp_byte_taken    = rsp_data.byte_taken;
   assign rsp_irq_raised    = rsp_data.irq_raised;

   // skid entry only fills behind a waiting result
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid entry valid without a result in the output register");

   // an irq only comes from a byte fetch
   a_irq_needs_fetch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_irq_raised) |-> rsp_byte_taken)
      else $error("irq raised on a result without a byte fetch");

   // an item taken while the output is stalled lands in the skid entry
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_valid && rsp_stall) |=> skid_full)
      else $error("item accepted under stall was not held in the skid entry");

   // no item enters while the remainder unit runs
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      $past(csr_wr_en && (csr_index == CSR_HALF_PER)) |-> !accept)
      else $error("item accepted during timer remainder computation");

endmodule
